// ----- design/bitmap_slab_allocator_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap slab allocator
// Clocked property checks, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLAB_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_SLAB_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/bsa_pkg.sv -----
// ---------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes of the bitmap slab allocator.
// ---------------------------------------------------------------------------
package bsa_pkg;

    localparam int DEF_SLAB_SLOTS = 16;
    localparam int UNITS_PER_SLAB = 64;
    localparam int LSB_IDX_W      = 8;

    localparam logic [UNITS_PER_SLAB-1:0] ALL_FREE = '1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT     = 2'd1;
    localparam logic [1:0] STAT_NOT_LIVE    = 2'd2;
    localparam logic [1:0] STAT_DOUBLE_FREE = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                 found;
        logic [LSB_IDX_W-1:0] idx;
    } lsb_res_t;

endpackage

// ----- design/bsa_lsb_enc.sv -----
// ---------------------------------------------------------------------------
// bsa_lsb_enc
// Lowest set bit finder, two levels: byte select, then bit within byte.
// ---------------------------------------------------------------------------
module bsa_lsb_enc
    import bsa_pkg::*;
#(
    parameter int W = UNITS_PER_SLAB
)
(
    input  logic [W-1:0] vec,
    output lsb_res_t     res
);

    localparam int G     = (W + 7) / 8;
    localparam int GRP_W = (G > 1) ? $clog2(G) : 1;
    localparam int IDX_W = $clog2(G * 8);

    logic [G*8-1:0]   pad;
    logic [G-1:0]     grp_nz;
    logic [GRP_W-1:0] grp_sel;
    logic [7:0]       byte_v;
    logic [2:0]       bit_sel;

    assign pad = (G * 8)'(vec);

    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_nz[g] = |pad[g*8 +: 8];
        end
        grp_sel = '0;
        for (int g = G - 1; g >= 0; g--)
        begin
            if (grp_nz[g])
            begin
                grp_sel = GRP_W'(g);
            end
        end
        byte_v  = pad[grp_sel*8 +: 8];
        bit_sel = '0;
        for (int b = 7; b >= 0; b--)
        begin
            if (byte_v[b])
            begin
                bit_sel = 3'(b);
            end
        end
    end

    assign res.found = |grp_nz;
    assign res.idx   = LSB_IDX_W'(IDX_W'({grp_sel, bit_sel}));

endmodule

// ----- design/bitmap_slab_allocator_top.sv -----
// ---------------------------------------------------------------------------
// bitmap_slab_allocator_top
// Slab pool with 64-unit free bitmaps and work/full slab lists.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ side. s_tuser is the operation (0 allocate,
//   1 free); s_tdata carries the slab and unit to free (ignored on allocate).
//   Each request yields exactly one response beat on the m_ side with the
//   status, the granted slab/unit, a release flag and the live and reserved
//   slab counts after the request.
//   Timing: a beat is taken in IDLE, which also issues the registered bitmap
//   read; EXEC then applies the read-modify-write and loads the output
//   register, which raises m_tvalid. A new request is taken only after the
//   previous one has left EXEC. The next request can be taken while a
//   response still waits downstream; a request only holds in the execute
//   cycle if the output register is still full.
//   Reset: slot 0 is live and alone on the work list, every bitmap is all
//   free (per-entry valid bits, no clearing pass), the keep limit is 1.
//   cfg_we/cfg_wdata write the keep limit; write only while idle.
// ---------------------------------------------------------------------------
module bitmap_slab_allocator_top
    import bsa_pkg::*;
#(
    parameter int SLAB_SLOTS = DEF_SLAB_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,     // keep limit for fully free slabs
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [3:0] slab_index, [9:4] unit_index, rest zero
    input  logic        s_tuser,       // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // [1:0] status, [5:2] granted_slab,
                                       // [11:6] granted_unit, [12] slab_released,
                                       // [17:13] live_slabs, [22:18] empty_slabs
);

    `include "bitmap_slab_allocator_top_assert.svh"

    localparam int SLOT_W = $clog2(SLAB_SLOTS);
    localparam int CNT_W  = $clog2(SLAB_SLOTS + 1);

    // control state
    state_t              state_reg, state_next;
    logic                exec_go;
    logic                accept;
    logic [4:0]          limit_reg;

    // request capture
    logic                func_reg;
    logic [3:0]          slab_reg;
    logic [5:0]          unit_reg;

    // bitmap memory, read data registered
    logic [UNITS_PER_SLAB-1:0] map_mem [SLAB_SLOTS];
    logic [SLAB_SLOTS-1:0]     map_vld_reg;
    logic [UNITS_PER_SLAB-1:0] rd_data_reg;
    logic                      rd_vld_reg;
    logic [SLOT_W-1:0]         rd_addr;
    logic [UNITS_PER_SLAB-1:0] cur_map;

    // slab lists
    logic [SLOT_W-1:0]     next_reg [SLAB_SLOTS];
    logic [SLOT_W-1:0]     prev_reg [SLAB_SLOTS];
    logic [SLOT_W-1:0]     next_n   [SLAB_SLOTS];
    logic [SLOT_W-1:0]     prev_n   [SLAB_SLOTS];
    logic [SLAB_SLOTS-1:0] live_reg, live_n;
    logic [SLOT_W-1:0]     work_head_reg, work_head_next;
    logic                  work_pres_reg, work_pres_next;
    logic [SLOT_W-1:0]     full_head_reg, full_head_next;
    logic                  full_pres_reg, full_pres_next;
    logic [CNT_W-1:0]      live_cnt_reg, live_cnt_next;
    logic [CNT_W-1:0]      empty_cnt_reg, empty_cnt_next;

    // execute results
    logic [UNITS_PER_SLAB-1:0] alloc_map;
    logic [UNITS_PER_SLAB-1:0] wr_data;
    logic                      wr_en;
    logic [SLOT_W-1:0]         tgt;
    lsb_res_t                  unit_res;
    lsb_res_t                  slot_res;
    logic [1:0]                status;
    logic [3:0]                g_slab;
    logic [5:0]                g_unit;
    logic                      released;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EXEC: exec_go  = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                exec_go  = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            limit_reg <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            slab_reg <= s_tdata[3:0];
            unit_reg <= s_tdata[9:4];
        end
    end

    // ---------------- bitmap memory ----------------
    // Free reads the addressed slab; allocate reads the work head.
    assign rd_addr = (s_tuser == FUNC_FREE) ? SLOT_W'(s_tdata[3:0]) : work_head_reg;

    always_ff @(posedge clk)
    begin
        if (exec_go && wr_en)
        begin
            map_mem[tgt] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // never-written entries read as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (exec_go && wr_en)
            begin
                map_vld_reg[tgt] <= 1'b1;
            end
            if (accept)
            begin
                rd_vld_reg <= map_vld_reg[rd_addr];
            end
        end
    end

    assign cur_map   = rd_vld_reg ? rd_data_reg : ALL_FREE;
    assign alloc_map = work_pres_reg ? cur_map : ALL_FREE;

    bsa_lsb_enc #(.W(UNITS_PER_SLAB)) u_unit_enc
    (
        .vec (alloc_map),
        .res (unit_res)
    );

    bsa_lsb_enc #(.W(SLAB_SLOTS)) u_slot_enc
    (
        .vec (~live_reg),
        .res (slot_res)
    );

    // ---------------- execute: modify and list update ----------------
    always_comb
    begin
        logic              do_rem;
        logic              rem_full;
        logic              do_ins;
        logic              ins_full;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        logic [SLOT_W-1:0] hd;
        logic              pres;
        logic [UNITS_PER_SLAB-1:0] bit_m;
        logic [4:0]        limit;

        do_rem   = 1'b0;
        rem_full = 1'b0;
        do_ins   = 1'b0;
        ins_full = 1'b0;
        nx       = '0;
        pv       = '0;
        hd       = '0;
        pres     = 1'b0;
        bit_m    = UNITS_PER_SLAB'(1) << unit_reg;
        limit    = (limit_reg == 5'd0) ? 5'd1 : limit_reg;

        next_n         = next_reg;
        prev_n         = prev_reg;
        live_n         = live_reg;
        work_head_next = work_head_reg;
        work_pres_next = work_pres_reg;
        full_head_next = full_head_reg;
        full_pres_next = full_pres_reg;
        live_cnt_next  = live_cnt_reg;
        empty_cnt_next = empty_cnt_reg;
        status         = STAT_OK;
        g_slab         = '0;
        g_unit         = '0;
        released       = 1'b0;
        wr_en          = 1'b0;
        wr_data        = cur_map;
        tgt            = SLOT_W'(slab_reg);

        if (func_reg == FUNC_ALLOC)
        begin
            if (!work_pres_reg)
            begin
                if (!slot_res.found)
                begin
                    status = STAT_NO_SLOT;
                end
                else
                begin
                    // open the lowest unused slot as the only work slab
                    tgt           = slot_res.idx[SLOT_W-1:0];
                    live_n[tgt]   = 1'b1;
                    live_cnt_next = live_cnt_reg + 1'b1;
                    do_ins        = 1'b1;
                end
            end
            else
            begin
                tgt = work_head_reg;
                if (cur_map == '0)
                begin
                    status = STAT_NO_SLOT;
                end
                else if (cur_map == ALL_FREE && empty_cnt_reg != '0)
                begin
                    empty_cnt_next = empty_cnt_reg - 1'b1;
                end
            end
            if (status == STAT_OK)
            begin
                wr_en   = 1'b1;
                wr_data = alloc_map & ~(UNITS_PER_SLAB'(1) << unit_res.idx[5:0]);
                g_slab  = 4'(tgt);
                g_unit  = unit_res.idx[5:0];
            end
        end
        else
        begin
            if (32'(slab_reg) >= SLAB_SLOTS || !live_reg[tgt])
            begin
                status = STAT_NOT_LIVE;
            end
            else if ((cur_map & bit_m) != '0)
            begin
                status = STAT_DOUBLE_FREE;
            end
            else
            begin
                wr_en   = 1'b1;
                wr_data = cur_map | bit_m;
            end
        end

        // placement changes after the bitmap update
        if (status == STAT_OK)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                if (wr_data == '0)
                begin
                    // open-new already inserted into the empty work list
                    if (do_ins)
                    begin
                        next_n[tgt]    = tgt;
                        prev_n[tgt]    = tgt;
                        work_pres_next = 1'b1;
                        work_head_next = tgt;
                    end
                    do_rem   = 1'b1;
                    rem_full = 1'b0;
                    do_ins   = 1'b1;
                    ins_full = 1'b1;
                end
            end
            else if (cur_map == '0)
            begin
                do_rem   = 1'b1;
                rem_full = 1'b1;
                do_ins   = 1'b1;
                ins_full = 1'b0;
            end
            else if (wr_data == ALL_FREE)
            begin
                empty_cnt_next = empty_cnt_reg + 1'b1;
                if (32'(empty_cnt_next) > 32'(limit))
                begin
                    do_rem      = 1'b1;
                    rem_full    = 1'b0;
                    live_n[tgt] = 1'b0;
                    if (live_cnt_reg != '0)
                    begin
                        live_cnt_next = live_cnt_reg - 1'b1;
                    end
                    empty_cnt_next = empty_cnt_reg;
                    released       = 1'b1;
                end
            end
        end

        if (do_rem)
        begin
            if (next_n[tgt] == tgt)
            begin
                if (rem_full)
                begin
                    full_pres_next = 1'b0;
                end
                else
                begin
                    work_pres_next = 1'b0;
                end
            end
            else
            begin
                nx         = next_n[tgt];
                pv         = prev_n[tgt];
                next_n[pv] = nx;
                prev_n[nx] = pv;
                if (rem_full)
                begin
                    if (full_head_next == tgt)
                    begin
                        full_head_next = nx;
                    end
                end
                else if (work_head_next == tgt)
                begin
                    work_head_next = nx;
                end
            end
        end

        if (do_ins)
        begin
            pres = ins_full ? full_pres_next : work_pres_next;
            hd   = ins_full ? full_head_next : work_head_next;
            if (pres)
            begin
                pv          = prev_n[hd];
                next_n[tgt] = hd;
                prev_n[tgt] = pv;
                prev_n[hd]  = tgt;
                next_n[pv]  = tgt;
            end
            else
            begin
                next_n[tgt] = tgt;
                prev_n[tgt] = tgt;
            end
            if (ins_full)
            begin
                full_pres_next = 1'b1;
                full_head_next = tgt;
            end
            else
            begin
                work_pres_next = 1'b1;
                work_head_next = tgt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLAB_SLOTS; i++)
            begin
                next_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
            live_reg      <= SLAB_SLOTS'(1);
            work_head_reg <= '0;
            work_pres_reg <= 1'b1;
            full_head_reg <= '0;
            full_pres_reg <= 1'b0;
            live_cnt_reg  <= CNT_W'(1);
            empty_cnt_reg <= CNT_W'(1);
        end
        else if (exec_go)
        begin
            next_reg      <= next_n;
            prev_reg      <= prev_n;
            live_reg      <= live_n;
            work_head_reg <= work_head_next;
            work_pres_reg <= work_pres_next;
            full_head_reg <= full_head_next;
            full_pres_reg <= full_pres_next;
            live_cnt_reg  <= live_cnt_next;
            empty_cnt_reg <= empty_cnt_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            m_tdata_reg <= {1'b0, 5'(empty_cnt_next), 5'(live_cnt_next), released,
                            g_unit, g_slab, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    `BSA_ASSERT(a_live_count, clk, rst_n, $countones(live_reg) == 32'(live_cnt_reg),
                "live count disagrees with live slots")
    `BSA_ASSERT(a_empty_le_live, clk, rst_n, empty_cnt_reg <= live_cnt_reg,
                "reserved count exceeds live count")
    `BSA_ASSERT_IMPL(a_work_live, clk, rst_n, work_pres_reg, live_reg[work_head_reg],
                     "work head is not a live slot")
    `BSA_ASSERT_IMPL(a_full_live, clk, rst_n, full_pres_reg, live_reg[full_head_reg],
                     "full head is not a live slot")
    `BSA_ASSERT_IMPL(a_resp_after_exec, clk, rst_n, $rose(m_tvalid_reg),
                     $past(state_reg == ST_EXEC), "response beat without execute cycle")

endmodule
